@@ design/ppc_pkg.sv @@
package ppc_pkg;

  typedef longint unsigned u64_t;

  localparam int COS_FRAC_BITS_DEF = 14;
  localparam int ROM_DEPTH         = 360;
  localparam int ANGLE_W           = 9;
  localparam int SUM_BASE          = 75;
  localparam int PALETTE_SIZE      = 252;
  localparam int COLOR_W           = 8;
  localparam int WORK_BITS         = 30;
  localparam u64_t PI_WORK         = 64'd3373259426;

  // pi * d / 180 at WORK_BITS fraction bits, rounded
  function automatic u64_t degrees_to_work(u64_t d);
    return (d * PI_WORK + 64'd90) / 64'd180;
  endfunction

  // eight terms past the first, divisors (2k-1)(2k)
  function automatic u64_t cos_series(u64_t a);
    u64_t a2;
    u64_t term;
    longint sum;
    a2   = (a * a) >> WORK_BITS;
    term = 64'd1 << WORK_BITS;
    sum  = longint'(term);
    term = ((term * a2) >> WORK_BITS) / 64'd2;
    sum  = sum - longint'(term);
    term = ((term * a2) >> WORK_BITS) / 64'd12;
    sum  = sum + longint'(term);
    term = ((term * a2) >> WORK_BITS) / 64'd30;
    sum  = sum - longint'(term);
    term = ((term * a2) >> WORK_BITS) / 64'd56;
    sum  = sum + longint'(term);
    term = ((term * a2) >> WORK_BITS) / 64'd90;
    sum  = sum - longint'(term);
    term = ((term * a2) >> WORK_BITS) / 64'd132;
    sum  = sum + longint'(term);
    term = ((term * a2) >> WORK_BITS) / 64'd182;
    sum  = sum - longint'(term);
    term = ((term * a2) >> WORK_BITS) / 64'd240;
    sum  = sum + longint'(term);
    return (sum < 0) ? 64'd0 : u64_t'(sum);
  endfunction

  // eight terms past the first, divisors (2k)(2k+1)
  function automatic u64_t sin_series(u64_t a);
    u64_t a2;
    u64_t term;
    longint sum;
    a2   = (a * a) >> WORK_BITS;
    term = a;
    sum  = longint'(term);
    term = ((term * a2) >> WORK_BITS) / 64'd6;
    sum  = sum - longint'(term);
    term = ((term * a2) >> WORK_BITS) / 64'd20;
    sum  = sum + longint'(term);
    term = ((term * a2) >> WORK_BITS) / 64'd42;
    sum  = sum - longint'(term);
    term = ((term * a2) >> WORK_BITS) / 64'd72;
    sum  = sum + longint'(term);
    term = ((term * a2) >> WORK_BITS) / 64'd110;
    sum  = sum - longint'(term);
    term = ((term * a2) >> WORK_BITS) / 64'd156;
    sum  = sum + longint'(term);
    term = ((term * a2) >> WORK_BITS) / 64'd210;
    sum  = sum - longint'(term);
    term = ((term * a2) >> WORK_BITS) / 64'd272;
    sum  = sum + longint'(term);
    return (sum < 0) ? 64'd0 : u64_t'(sum);
  endfunction

  function automatic u64_t quarter_cos(u64_t d);
    if (d <= 64'd45) begin
      return cos_series(degrees_to_work(d));
    end
    return sin_series(degrees_to_work(64'd90 - d));
  endfunction

  // cos of d degrees, frac_bits fraction bits, ties away from zero
  function automatic longint cos_entry(u64_t d, int frac_bits);
    int   shift;
    u64_t half;
    u64_t q;
    u64_t r;
    logic neg;
    shift = WORK_BITS - frac_bits;
    half  = 64'd1 << (shift - 1);
    if (d <= 64'd90) begin
      q = d;
      neg = 1'b0;
    end else if (d <= 64'd180) begin
      q = 64'd180 - d;
      neg = 1'b1;
    end else if (d <= 64'd270) begin
      q = d - 64'd180;
      neg = 1'b1;
    end else begin
      q = 64'd360 - d;
      neg = 1'b0;
    end
    r = (quarter_cos(q) + half) >> shift;
    return neg ? -longint'(r) : longint'(r);
  endfunction

endpackage

@@ design/ppc_cos_rom.sv @@
module ppc_cos_rom #(
  parameter int FRAC_BITS = ppc_pkg::COS_FRAC_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               en_i,
  input  logic        [ppc_pkg::ANGLE_W-1:0] addr_i,
  output logic signed [FRAC_BITS+1:0]        data_o
);

  localparam int CW = FRAC_BITS + 2;

  typedef logic signed [CW-1:0] rom_t [ppc_pkg::ROM_DEPTH];

  function automatic rom_t build_rom();
    rom_t t;
    for (int d = 0; d < ppc_pkg::ROM_DEPTH; d++) begin
      t[d] = CW'(ppc_pkg::cos_entry(ppc_pkg::u64_t'(d), FRAC_BITS));
    end
    return t;
  endfunction

  localparam rom_t CosRom = build_rom();

  logic signed [CW-1:0] data_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= CosRom[addr_i];
    end
  end

  assign data_o = data_q;

endmodule

@@ design/plasma_pixel_color_core.sv @@
// Plasma palette index per pixel. One request is taken every clock when the
// output side keeps up; each accepted request moves through registered stages
// in order (angle reduction and cosine ROM read, row and column sums, product,
// reduction modulo 252). The six cosine look-ups go to six copies of a
// 360-entry ROM with registered read data, so the ROM ports set the one
// pixel per clock figure. Stages advance independently, so empty stages are
// filled while a result waits at the output. The ROM is constant: no clearing
// pass after reset.
module plasma_pixel_color_core #(
  parameter int COS_FRAC_BITS = ppc_pkg::COS_FRAC_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [8:0]                         pixel_x_i,
  input  logic [7:0]                         pixel_y_i,
  input  logic [9:0]                         frame_phase_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [ppc_pkg::COLOR_W-1:0]        color_index_o
);

  localparam int F      = COS_FRAC_BITS;
  localparam int CW     = F + 2;
  localparam int SW     = F + 8;
  localparam int UW     = F + 7;
  localparam int PW     = 2 * UW;
  localparam int IW     = 13;
  localparam int NCOS   = 6;
  localparam logic signed [SW-1:0] Base = SW'(ppc_pkg::SUM_BASE * (2 ** F));

  function automatic logic [ppc_pkg::ANGLE_W-1:0] mod360(logic [11:0] a);
    logic [19:0] m;
    logic [2:0]  q;
    logic [11:0] r;
    m = 20'(a) * 20'd182;
    q = m[18:16];
    r = a - 12'(q) * 12'd360;
    if (r >= 12'd360) begin
      r = r - 12'd360;
    end
    return r[ppc_pkg::ANGLE_W-1:0];
  endfunction

  function automatic logic [ppc_pkg::COLOR_W-1:0] mod252(logic [IW-1:0] v);
    logic [21:0]   m;
    logic [5:0]    q;
    logic [IW-1:0] r;
    m = 22'(v) * 22'd260;
    q = m[21:16];
    r = v - IW'(q) * IW'(ppc_pkg::PALETTE_SIZE);
    if (r >= IW'(ppc_pkg::PALETTE_SIZE)) begin
      r = r - IW'(ppc_pkg::PALETTE_SIZE);
    end
    return r[ppc_pkg::COLOR_W-1:0];
  endfunction

  logic en1, en2, en3, en4;
  logic v1_q, v2_q, v3_q, out_valid_q;

  logic [ppc_pkg::ANGLE_W-1:0] addr [NCOS];
  logic signed [CW-1:0]        cos_q [NCOS];

  logic signed [SW-1:0] ysum_full, xsum_full;
  logic [UW-1:0]        ysum_d, xsum_d, ysum_q, xsum_q;
  logic [PW-1:0]        prod_full;
  logic [IW-1:0]        int_d, int_q;
  logic [ppc_pkg::COLOR_W-1:0] color_d, color_q;

  assign en4 = !out_valid_q || out_ready_i;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign in_ready_o = en1;

  // row angles: y+2p, 2y+p/2, y+p; column angles: 2x+p/2, x+2p, x/2+p
  assign addr[0] = mod360(12'(pixel_y_i) + 12'({frame_phase_i, 1'b0}));
  assign addr[1] = mod360(12'({pixel_y_i, 1'b0}) + 12'(frame_phase_i[9:1]));
  assign addr[2] = mod360(12'(pixel_y_i) + 12'(frame_phase_i));
  assign addr[3] = mod360(12'({pixel_x_i, 1'b0}) + 12'(frame_phase_i[9:1]));
  assign addr[4] = mod360(12'(pixel_x_i) + 12'({frame_phase_i, 1'b0}));
  assign addr[5] = mod360(12'(pixel_x_i[8:1]) + 12'(frame_phase_i));

  for (genvar k = 0; k < NCOS; k++) begin : g_rom
    ppc_cos_rom #(
      .FRAC_BITS(F)
    ) u_rom (
      .clk_i (clk_i),
      .en_i  (en1),
      .addr_i(addr[k]),
      .data_o(cos_q[k])
    );
  end

  always_comb begin
    ysum_full = Base + (SW'(cos_q[0]) <<< 1) + SW'(cos_q[1]) + (SW'(cos_q[2]) <<< 1);
    xsum_full = Base + SW'(cos_q[3]) + SW'(cos_q[4]) + (SW'(cos_q[5]) <<< 1);
    ysum_d    = ysum_full[UW-1:0];
    xsum_d    = xsum_full[UW-1:0];
    prod_full = PW'(xsum_q) * PW'(ysum_q);
    int_d     = prod_full[2*F+IW-1:2*F];
    color_d   = mod252(int_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (en1) begin
        v1_q <= in_valid_i;
      end
      if (en2) begin
        v2_q <= v1_q;
      end
      if (en3) begin
        v3_q <= v2_q;
      end
      if (en4) begin
        out_valid_q <= v3_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      ysum_q <= ysum_d;
      xsum_q <= xsum_d;
    end
    if (en3) begin
      int_q <= int_d;
    end
    if (en4) begin
      color_q <= color_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign color_index_o = color_q;

  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> v1_q)
    else $error("accepted request did not reach the ROM stage");

  a_sum_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q && !en2 |=> v2_q && $stable(xsum_q) && $stable(ysum_q))
    else $error("stalled sums changed");

  a_sum_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q |-> (xsum_q >= UW'(70 * (2 ** F))) && (xsum_q <= UW'(80 * (2 ** F))) &&
             (ysum_q >= UW'(70 * (2 ** F))) && (ysum_q <= UW'(80 * (2 ** F))))
    else $error("row or column sum out of range");

  a_color_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q && en4 |=> out_valid_o && (color_index_o < ppc_pkg::COLOR_W'(ppc_pkg::PALETTE_SIZE)))
    else $error("colour index not reduced");

endmodule
